// File: design/lsbf_pkg.sv
// Shared constants, types and trig tables for the L-shape box fitter.
package lsbf_pkg;

    // sizing
    localparam int MAX_POINTS = 256;
    localparam int NUM_ANGLES = 90;
    localparam int FRAC_BITS  = 10;

    localparam int PT_W      = 24;
    localparam int TRIG_BITS = 14;
    localparam int TW        = TRIG_BITS + 1;        // cos/sin magnitude, Q1.14
    localparam int CW        = TW + 1;               // signed multiplier operand
    localparam int PW        = PT_W + 2;             // projected coordinate
    localparam int AW        = $clog2(MAX_POINTS);
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int ANG_W     = $clog2(NUM_ANGLES);
    localparam int DEG_W     = 7;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int QW        = FRAC_BITS + 23;       // reciprocal quotient
    localparam int SCORE_W   = 48;
    localparam int NSUM_W    = 2 * PW + CNT_W;
    localparam int ANG_DEN   = NUM_ANGLES - 1;
    localparam int CX_W      = PW + 2;               // doubled center, rotated frame
    localparam int CM_W      = CW + CX_W;

    localparam logic [QW-1:0] SCORE_NUM = QW'(1) << (FRAC_BITS + 22);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BOX  = 1'b1;
    localparam logic [CFG_W-1:0] RST_MIN_DIST = 16'd10;
    localparam logic [CFG_W-1:0] RST_MIN_BOX  = 16'd205;

    localparam longint unsigned PI_DEG_Q30  = 64'd18740330;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    typedef logic [TW-1:0]    t_trig_tbl [NUM_ANGLES];
    typedef logic [DEG_W-1:0] t_deg_tbl  [NUM_ANGLES];

    // Taylor series sine, Q30 in and out
    function automatic longint unsigned f_sin_q30(longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    function automatic longint unsigned f_angle_q30(int j);
        longint unsigned jj;
        jj = longint'(j);
        return (jj * 64'd89 * PI_DEG_Q30 + ANG_DEN / 2) / ANG_DEN;
    endfunction

    function automatic t_trig_tbl f_sin_tbl();
        t_trig_tbl tbl;
        for (int j = 0; j < NUM_ANGLES; j++) begin
            tbl[j] = TW'((f_sin_q30(f_angle_q30(j)) + 64'd32768) >> 16);
        end
        return tbl;
    endfunction

    function automatic t_trig_tbl f_cos_tbl();
        t_trig_tbl tbl;
        for (int j = 0; j < NUM_ANGLES; j++) begin
            tbl[j] = TW'((f_sin_q30(HALF_PI_Q30 - f_angle_q30(j)) + 64'd32768) >> 16);
        end
        return tbl;
    endfunction

    function automatic t_deg_tbl f_deg_tbl();
        t_deg_tbl tbl;
        for (int j = 0; j < NUM_ANGLES; j++) begin
            tbl[j] = DEG_W'((j * 89 + ANG_DEN / 2) / ANG_DEN);
        end
        return tbl;
    endfunction

    localparam t_trig_tbl SIN_TBL = f_sin_tbl();
    localparam t_trig_tbl COS_TBL = f_cos_tbl();
    localparam t_deg_tbl  DEG_TBL = f_deg_tbl();

endpackage

// File: design/lsbf_if.sv
// Channel interfaces: cluster points in, box results out, register writes.
interface lsbf_pt_if import lsbf_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] vehicle_x;
    logic signed [PT_W-1:0] vehicle_y;
    logic                   last_point;

    modport source (output valid, point_x, point_y, vehicle_x, vehicle_y, last_point,
                    input ready);
    modport sink   (input valid, point_x, point_y, vehicle_x, vehicle_y, last_point,
                    output ready);
endinterface

interface lsbf_box_if import lsbf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PT_W-1:0]  center_x;
    logic signed [PT_W-1:0]  center_y;
    logic        [PT_W-1:0]  box_size;
    logic        [DEG_W-1:0] angle_index;
    logic                    points_dropped;

    modport source (output valid, center_x, center_y, box_size, angle_index, points_dropped,
                    input ready);
    modport sink   (input valid, center_x, center_y, box_size, angle_index, points_dropped,
                    output ready);
endinterface

interface lsbf_cfg_if import lsbf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/lsbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/lsbf_div.sv
// Bit-serial restoring divider: fixed score numerator over a distance, one bit a cycle.
module lsbf_div import lsbf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [PW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quo
);
    localparam int STEP_W = $clog2(QW + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [PW:0]       r_rem;
    logic [QW-1:0]     r_quo;
    logic [PW-1:0]     r_den;
    logic [PW:0]       trial;
    logic              fits;

    // shift in the next dividend bit and try the subtract
    assign trial = {r_rem[PW-1:0], r_quo[QW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(QW);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= SCORE_NUM;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? trial - {1'b0, r_den} : trial;
            r_quo <= {r_quo[QW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// File: design/lshape_box_fitting.sv
// Top level: point store, angle search sequencer and box placement.
//
//  channel  modport  carries                                            accepted when
//  i_pt     sink     point_x/y, vehicle_x/y, last_point                 valid & ready
//  o_box    source   center_x/y, box_size, angle_index, points_dropped  valid & ready
//  i_cfg    sink     index, data (min_point_dist, min_box_size)         valid & ready
//
// A point that is not last is written to the store, or dropped once it is full; ready is high whenever no fit runs.
// A fit is paced by the bit-serial reciprocal divider (one quotient bit a cycle)
// and the single store read port.
// Reset (synchronous, active low) empties the store and restores the register defaults.
// A finished result waits in the output register; the next cluster may load meanwhile,
// and a fit that ends while the previous result is untaken holds until it is taken.
module lshape_box_fitting import lsbf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lsbf_pt_if.sink    i_pt,
    lsbf_box_if.source o_box,
    lsbf_cfg_if.sink   i_cfg
);
    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_RD      = 17'h00002,
        S_MUL     = 17'h00004,
        S_PRJ     = 17'h00008,
        S_BND     = 17'h00010,
        S_DIF     = 17'h00020,
        S_SQ      = 17'h00040,
        S_NACC    = 17'h00080,
        S_NEND    = 17'h00100,
        S_DST     = 17'h00200,
        S_DIV     = 17'h00400,
        S_ANG_END = 17'h00800,
        S_CDIF    = 17'h01000,
        S_CSQ     = 17'h02000,
        S_CCMP    = 17'h04000,
        S_CTR     = 17'h08000,
        S_OUT     = 17'h10000
    } t_state;

    typedef enum logic [1:0] {P_BND, P_NRM, P_SCR, P_FIN} t_pass;

    t_state r_state, n_state;
    t_pass  r_pass;

    // control
    logic [CNT_W-1:0]   r_cnt;
    logic               r_ovf;
    logic [CNT_W-1:0]   r_n;
    logic [AW-1:0]      r_idx;
    logic               r_drop;
    logic [ANG_W-1:0]   r_ang;
    logic [ANG_W-1:0]   r_best_ang;
    logic [SCORE_W-1:0] r_best_score;
    logic [SCORE_W-1:0] r_score;
    logic               r_veh;
    logic [1:0]         r_k;
    logic [CFG_W-1:0]   r_min_dist;
    logic [CFG_W-1:0]   r_min_box;
    logic               r_ov;

    // datapath
    logic signed [PT_W-1:0]   r_vx, r_vy;
    logic        [TW-1:0]     r_c, r_s;
    logic signed [PT_W+CW-1:0] r_pxc, r_pys, r_pyc, r_pxs;
    logic signed [PW-1:0]     r_pa, r_pb;
    logic signed [PW-1:0]     r_mx1, r_mn1, r_mx2, r_mn2;
    logic        [PW-1:0]     r_a0, r_a1, r_b0, r_b1;
    logic        [2*PW-1:0]   r_q0, r_q1, r_q2, r_q3;
    logic        [NSUM_W-1:0] r_n10, r_n11, r_n20, r_n21;
    logic                     r_use11, r_use21;
    logic signed [PW:0]       r_dx, r_dy;
    logic        [2*PW+1:0]   r_dxx, r_dyy;
    logic        [2*PW+2:0]   r_best_d;
    logic        [1:0]        r_best_k;
    logic        [PW-1:0]     r_size;
    logic signed [CM_W-1:0]   r_mcx, r_mscy, r_mscx, r_mccy;
    logic signed [PT_W-1:0]   r_out_x, r_out_y;
    logic        [PT_W-1:0]   r_out_size;
    logic        [DEG_W-1:0]  r_out_deg;
    logic                     r_out_drop;

    logic                     pt_acc, cfg_acc, full, last_idx;
    logic [2*PT_W-1:0]        ram_rdata;
    logic signed [PT_W-1:0]   mul_x, mul_y;
    logic signed [CW-1:0]     c_s, s_s;
    logic signed [PT_W+CW:0]  sum_a, sum_b;
    logic        [PW-1:0]     d1, d2, dmin, dfl, den;
    logic                     div_done;
    logic        [QW-1:0]     div_quo;
    logic        [SCORE_W:0]  score_sum;
    logic                     ang_upd, ang_last;
    logic        [ANG_W-1:0]  ang_win;
    logic signed [PW-1:0]     cor1, cor2, k_cor1, k_cor2;
    logic        [2*PW+2:0]   dd;
    logic        [PW-1:0]     rng1, rng2, size_m;
    logic signed [CX_W-1:0]   cx2, cy2;
    logic signed [CM_W:0]     ctr_x, ctr_y;
    logic signed [CM_W-15:0]  ctr_xs, ctr_ys;
    logic                     out_free;

    assign pt_acc   = i_pt.valid && i_pt.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign full     = r_cnt == CNT_W'(MAX_POINTS);
    assign last_idx = CNT_W'(r_idx) == r_n - CNT_W'(1);

    assign i_pt.ready  = r_state == S_IDLE;
    assign i_cfg.ready = 1'b1;

    // point store, x in the upper half
    lsbf_ram #(.WIDTH(2 * PT_W), .DEPTH(MAX_POINTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (pt_acc && !full),
        .i_waddr(r_cnt[AW-1:0]),
        .i_wdata({i_pt.point_x, i_pt.point_y}),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    // projection operands
    assign mul_x = r_veh ? r_vx : $signed(ram_rdata[2*PT_W-1:PT_W]);
    assign mul_y = r_veh ? r_vy : $signed(ram_rdata[PT_W-1:0]);
    assign c_s   = $signed({1'b0, r_c});
    assign s_s   = $signed({1'b0, r_s});
    assign sum_a = (PT_W+CW+1)'(r_pxc) + (PT_W+CW+1)'(r_pys) + (PT_W+CW+1)'(1 <<< 13);
    assign sum_b = (PT_W+CW+1)'(r_pyc) - (PT_W+CW+1)'(r_pxs) + (PT_W+CW+1)'(1 <<< 13);

    // distance to the chosen edges, floored
    assign d1   = r_use11 ? PW'(r_pa - r_mn1) : PW'(r_mx1 - r_pa);
    assign d2   = r_use21 ? PW'(r_pb - r_mn2) : PW'(r_mx2 - r_pb);
    assign dmin = (d1 < d2) ? d1 : d2;
    assign dfl  = (r_min_dist == '0) ? PW'(1) : PW'(r_min_dist);
    assign den  = (dmin < dfl) ? dfl : dmin;

    lsbf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == S_DST),
        .i_den  (den),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    assign score_sum = {1'b0, r_score} + (SCORE_W+1)'(div_quo);

    // angle bookkeeping
    assign ang_upd  = r_score > r_best_score;
    assign ang_win  = ang_upd ? r_ang : r_best_ang;
    assign ang_last = r_ang == ANG_W'(NUM_ANGLES - 1);

    // corner selection and box size
    assign k_cor1 = r_k[1] ? r_mn1 : r_mx1;
    assign k_cor2 = r_k[0] ? r_mn2 : r_mx2;
    assign cor1   = r_best_k[1] ? r_mn1 : r_mx1;
    assign cor2   = r_best_k[0] ? r_mn2 : r_mx2;
    assign dd     = (2*PW+3)'(r_dxx) + (2*PW+3)'(r_dyy);
    assign rng1   = PW'(r_mx1 - r_mn1);
    assign rng2   = PW'(r_mx2 - r_mn2);
    assign size_m = (rng1 > rng2) ? rng1 : rng2;
    assign cx2 = (CX_W'(cor1) <<< 1) + (r_best_k[1] ? CX_W'($signed({1'b0, r_size}))
                                                     : -CX_W'($signed({1'b0, r_size})));
    assign cy2 = (CX_W'(cor2) <<< 1) + (r_best_k[0] ? CX_W'($signed({1'b0, r_size}))
                                                     : -CX_W'($signed({1'b0, r_size})));

    // rotate the doubled center back, halve with rounding
    assign ctr_x  = (CM_W+1)'(r_mcx) - (CM_W+1)'(r_mscy) + (CM_W+1)'(1 <<< 14);
    assign ctr_y  = (CM_W+1)'(r_mscx) + (CM_W+1)'(r_mccy) + (CM_W+1)'(1 <<< 14);
    assign ctr_xs = ctr_x[CM_W:15];
    assign ctr_ys = ctr_y[CM_W:15];
    assign out_free = !r_ov || o_box.ready;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (pt_acc && i_pt.last_point) n_state = S_RD;
            S_RD:      n_state = S_MUL;
            S_MUL:     n_state = S_PRJ;
            S_PRJ: begin
                if (r_veh) begin
                    n_state = S_CDIF;
                end else begin
                    case (r_pass)
                        P_NRM:   n_state = S_DIF;
                        P_SCR:   n_state = S_DST;
                        default: n_state = S_BND;
                    endcase
                end
            end
            S_BND: begin
                if (!last_idx)           n_state = S_RD;
                else if (r_pass == P_FIN) n_state = S_MUL;
                else                      n_state = S_RD;
            end
            S_DIF:     n_state = S_SQ;
            S_SQ:      n_state = S_NACC;
            S_NACC:    n_state = last_idx ? S_NEND : S_RD;
            S_NEND:    n_state = S_RD;
            S_DST:     n_state = S_DIV;
            S_DIV:     if (div_done) n_state = last_idx ? S_ANG_END : S_RD;
            S_ANG_END: n_state = S_RD;
            S_CDIF:    n_state = S_CSQ;
            S_CSQ:     n_state = S_CCMP;
            S_CCMP:    n_state = (r_k == 2'd3) ? S_CTR : S_CDIF;
            S_CTR:     n_state = S_OUT;
            S_OUT:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_ovf        <= 1'b0;
            r_best_score <= '0;
            r_best_ang   <= '0;
            r_min_dist   <= RST_MIN_DIST;
            r_min_box    <= RST_MIN_BOX;
            r_ov         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                case (i_cfg.index)
                    CFG_MIN_DIST: r_min_dist <= i_cfg.data;
                    CFG_MIN_BOX:  r_min_box  <= i_cfg.data;
                    default: ;
                endcase
            end
            if (pt_acc) begin
                if (i_pt.last_point) begin
                    r_cnt        <= '0;
                    r_ovf        <= 1'b0;
                    r_best_score <= '0;
                    r_best_ang   <= '0;
                end else if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            if (r_state == S_ANG_END && ang_upd) begin
                r_best_score <= r_score;
                r_best_ang   <= r_ang;
            end
            if (r_ov && o_box.ready) r_ov <= 1'b0;
            if (r_state == S_OUT && out_free) r_ov <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (pt_acc && i_pt.last_point) begin
                    r_n    <= full ? r_cnt : r_cnt + CNT_W'(1);
                    r_drop <= r_ovf || full;
                    r_vx   <= i_pt.vehicle_x;
                    r_vy   <= i_pt.vehicle_y;
                    r_ang  <= '0;
                    r_c    <= COS_TBL[0];
                    r_s    <= SIN_TBL[0];
                    r_pass <= P_BND;
                    r_idx  <= '0;
                    r_veh  <= 1'b0;
                end
            end
            S_MUL: begin
                r_pxc <= mul_x * c_s;
                r_pys <= mul_y * s_s;
                r_pyc <= mul_y * c_s;
                r_pxs <= mul_x * s_s;
            end
            S_PRJ: begin
                r_pa <= PW'(sum_a >>> 14);
                r_pb <= PW'(sum_b >>> 14);
                r_k  <= 2'd0;
            end
            S_BND: begin
                if (r_idx == '0) begin
                    r_mx1 <= r_pa;
                    r_mn1 <= r_pa;
                    r_mx2 <= r_pb;
                    r_mn2 <= r_pb;
                end else begin
                    if (r_pa > r_mx1) r_mx1 <= r_pa;
                    if (r_pa < r_mn1) r_mn1 <= r_pa;
                    if (r_pb > r_mx2) r_mx2 <= r_pb;
                    if (r_pb < r_mn2) r_mn2 <= r_pb;
                end
                if (!last_idx) begin
                    r_idx <= r_idx + AW'(1);
                end else if (r_pass == P_FIN) begin
                    r_veh <= 1'b1;
                end else begin
                    r_idx <= '0;
                    r_pass <= P_NRM;
                    r_n10 <= '0;
                    r_n11 <= '0;
                    r_n20 <= '0;
                    r_n21 <= '0;
                end
            end
            S_DIF: begin
                r_a0 <= PW'(r_mx1 - r_pa);
                r_a1 <= PW'(r_pa - r_mn1);
                r_b0 <= PW'(r_mx2 - r_pb);
                r_b1 <= PW'(r_pb - r_mn2);
            end
            S_SQ: begin
                r_q0 <= r_a0 * r_a0;
                r_q1 <= r_a1 * r_a1;
                r_q2 <= r_b0 * r_b0;
                r_q3 <= r_b1 * r_b1;
            end
            S_NACC: begin
                r_n10 <= r_n10 + NSUM_W'(r_q0);
                r_n11 <= r_n11 + NSUM_W'(r_q1);
                r_n20 <= r_n20 + NSUM_W'(r_q2);
                r_n21 <= r_n21 + NSUM_W'(r_q3);
                r_idx <= last_idx ? '0 : r_idx + AW'(1);
            end
            S_NEND: begin
                r_use11 <= r_n10 > r_n11;
                r_use21 <= r_n20 > r_n21;
                r_pass  <= P_SCR;
                r_score <= '0;
            end
            S_DIV: begin
                if (div_done) begin
                    r_score <= score_sum[SCORE_W] ? '1 : score_sum[SCORE_W-1:0];
                    r_idx   <= last_idx ? '0 : r_idx + AW'(1);
                end
            end
            S_ANG_END: begin
                if (ang_last) begin
                    r_pass <= P_FIN;
                    r_c    <= COS_TBL[ang_win];
                    r_s    <= SIN_TBL[ang_win];
                end else begin
                    r_pass <= P_BND;
                    r_ang  <= r_ang + ANG_W'(1);
                    r_c    <= COS_TBL[r_ang + ANG_W'(1)];
                    r_s    <= SIN_TBL[r_ang + ANG_W'(1)];
                end
            end
            S_CDIF: begin
                r_dx <= (PW+1)'(k_cor1) - (PW+1)'(r_pa);
                r_dy <= (PW+1)'(k_cor2) - (PW+1)'(r_pb);
            end
            S_CSQ: begin
                r_dxx <= (2*PW+2)'(r_dx * r_dx);
                r_dyy <= (2*PW+2)'(r_dy * r_dy);
            end
            S_CCMP: begin
                if (r_k == 2'd0 || dd < r_best_d) begin
                    r_best_d <= dd;
                    r_best_k <= r_k;
                end
                r_k <= r_k + 2'd1;
                r_size <= (PW'(r_min_box) > size_m) ? PW'(r_min_box) : size_m;
            end
            S_CTR: begin
                r_mcx  <= c_s * cx2;
                r_mscy <= s_s * cy2;
                r_mscx <= s_s * cx2;
                r_mccy <= c_s * cy2;
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_x <= (ctr_xs > (CM_W-14)'(8388607)) ? PT_W'(8388607)
                             : (ctr_xs < -(CM_W-14)'(8388608)) ? PT_W'(-8388608)
                             : PT_W'(ctr_xs);
                    r_out_y <= (ctr_ys > (CM_W-14)'(8388607)) ? PT_W'(8388607)
                             : (ctr_ys < -(CM_W-14)'(8388608)) ? PT_W'(-8388608)
                             : PT_W'(ctr_ys);
                    r_out_size <= (r_size > PW'(24'hFFFFFF)) ? '1 : PT_W'(r_size);
                    r_out_deg  <= DEG_TBL[r_best_ang];
                    r_out_drop <= r_drop;
                end
            end
            default: ;
        endcase
    end

    assign o_box.valid          = r_ov;
    assign o_box.center_x       = r_out_x;
    assign o_box.center_y       = r_out_y;
    assign o_box.box_size       = r_out_size;
    assign o_box.angle_index    = r_out_deg;
    assign o_box.points_dropped = r_out_drop;
endmodule
